### sv/gpp_pkg.sv
// ============================================================================
// gpp_pkg - shared types and constants of the game port paddle timers
// Op codes, fixed field widths and register indexes used by the channel
// interfaces and by the top level.
// ============================================================================
`default_nettype none

package gpp_pkg;

    // Fixed field widths of the command and status words
    localparam int OP_W       = 3;
    localparam int CYCLES_W   = 16;
    localparam int PSEL_W     = 2;
    localparam int RATE_W     = 16;
    localparam int BSEL_W     = 2;
    localparam int BUSY_W     = 4;
    localparam int NUM_BUTTONS = 3;

    // Configuration port
    localparam int APB_DW     = 32;
    localparam int APB_AW     = 3;
    localparam int BOUND_W    = 16;

    // Register indexes (paddr[2])
    typedef enum logic
    {
        REG_POS_MIN = 1'b0,
        REG_POS_MAX = 1'b1
    } reg_idx_t;

    // Reset value of the clamp ceiling
    localparam logic [BOUND_W-1:0] POS_MAX_RESET = 16'd3000;

    // Command op codes; codes 5..7 are no-ops
    typedef enum logic [OP_W-1:0]
    {
        OP_TICK     = 3'd0,
        OP_TRIGGER  = 3'd1,
        OP_POLL     = 3'd2,
        OP_SET_RATE = 3'd3,
        OP_BUTTON   = 3'd4
    } op_t;

endpackage : gpp_pkg

`default_nettype wire

### sv/gpp_intf.sv
// ============================================================================
// gpp_intf - valid/ready channels of the game port paddle timers
// gpp_cmd_if carries one command word, gpp_status_if one status word.
// ============================================================================
`default_nettype none

interface gpp_cmd_if;
    import gpp_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [OP_W-1:0]          op;
    logic [CYCLES_W-1:0]      cycles;
    logic [PSEL_W-1:0]        paddle_sel;
    logic signed [RATE_W-1:0] rate;
    logic [BSEL_W-1:0]        button_sel;
    logic                     level;

    modport source
    (
        output valid, op, cycles, paddle_sel, rate, button_sel, level,
        input  ready
    );

    modport sink
    (
        input  valid, op, cycles, paddle_sel, rate, button_sel, level,
        output ready
    );
endinterface : gpp_cmd_if

interface gpp_status_if;
    import gpp_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [BUSY_W-1:0]      paddle_busy;
    logic [NUM_BUTTONS-1:0] buttons;

    modport source
    (
        output valid, paddle_busy, buttons,
        input  ready
    );

    modport sink
    (
        input  valid, paddle_busy, buttons,
        output ready
    );
endinterface : gpp_status_if

`default_nettype wire

### sv/game_port_paddle_timers_top.sv
// ============================================================================
// game_port_paddle_timers_top - four-paddle game port with one-shot timers
// Keeps position, countdown and drift per paddle plus three button flags;
// every command word returns the countdown-running and button bits.
// ============================================================================
// Usage:
//   cmd    : command words (op, cycles, paddle_sel, rate, button_sel, level),
//            taken on valid & ready.
//   status : one status word per command (paddle_busy, buttons), taken on
//            valid & ready. Bits reflect the state after the command.
//   APB    : pos_min at 0x0, pos_max at 0x4, 16 bits each, readable.
//            Write only while no command is in flight.
// Pipeline: a command taken on cmd passes through the input register, then
//   the state update and status register.
// Throughput: one command per cycle unless status is held off; all paddles
//   update in parallel, each by one saturating subtract or one add and clamp.
// Reset: positions, countdowns, drifts and buttons clear to zero, pos_min
//   to 0, pos_max to 3000; both pipeline stages empty.
// Stall: while status is held off, the held command waits in the input
//   register and state does not change; one more command can be taken
//   before cmd.ready drops.
// ============================================================================
`default_nettype none

module game_port_paddle_timers_top
#(
    parameter int NUM_PADDLES = 4,
    parameter int POS_WIDTH   = 16
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,

    gpp_cmd_if.sink                         cmd,
    gpp_status_if.source                    status,

    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [gpp_pkg::APB_AW-1:0] paddr,
    input  wire logic [gpp_pkg::APB_DW-1:0] pwdata,
    output logic      [gpp_pkg::APB_DW-1:0] prdata,
    output logic                            pready
);
    import gpp_pkg::*;

    // Widths for compares and the signed clamp sum
    localparam int XW     = (POS_WIDTH > BOUND_W) ? POS_WIDTH : BOUND_W;
    localparam int SW     = XW + 2;
    localparam int BUSY_N = (NUM_PADDLES < BUSY_W) ? NUM_PADDLES : BUSY_W;
    localparam logic [XW-1:0] POS_LIMIT = XW'((64'd1 << POS_WIDTH) - 64'd1);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [BOUND_W-1:0] pos_min_reg;
    logic [BOUND_W-1:0] pos_max_reg;
    logic               cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_min_reg <= '0;
            pos_max_reg <= POS_MAX_RESET;
        end
        else if (cfg_wr)
        begin
            case (reg_idx_t'(paddr[2]))
                REG_POS_MIN: pos_min_reg <= pwdata[BOUND_W-1:0];
                REG_POS_MAX: pos_max_reg <= pwdata[BOUND_W-1:0];
                default:     pos_min_reg <= pos_min_reg;
            endcase
        end
    end

    // Register readback
    always_comb
    begin
        case (reg_idx_t'(paddr[2]))
            REG_POS_MIN: prdata = APB_DW'(pos_min_reg);
            REG_POS_MAX: prdata = APB_DW'(pos_max_reg);
            default:     prdata = '0;
        endcase
    end

    // Bounds saturated to the position range
    logic [XW-1:0]        lo_ext;
    logic [XW-1:0]        hi_ext;
    logic [POS_WIDTH-1:0] lo_cap;
    logic [POS_WIDTH-1:0] hi_cap;

    assign lo_ext = XW'(pos_min_reg);
    assign hi_ext = XW'(pos_max_reg);
    assign lo_cap = (lo_ext > POS_LIMIT) ? POS_LIMIT[POS_WIDTH-1:0] : lo_ext[POS_WIDTH-1:0];
    assign hi_cap = (hi_ext > POS_LIMIT) ? POS_LIMIT[POS_WIDTH-1:0] : hi_ext[POS_WIDTH-1:0];

    // ------------------------------------------------------------------
    // Pipeline control
    // ------------------------------------------------------------------
    logic s1_valid_reg;
    logic out_valid_reg;
    logic advance;
    logic fire;
    logic cmd_take;

    assign advance   = !out_valid_reg || status.ready;
    assign fire      = s1_valid_reg && advance;
    assign cmd.ready = !s1_valid_reg || advance;
    assign cmd_take  = cmd.valid && cmd.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.ready)
            begin
                s1_valid_reg <= cmd.valid;
            end
            if (advance)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    // Input register
    logic [OP_W-1:0]          s1_op_reg;
    logic [CYCLES_W-1:0]      s1_cycles_reg;
    logic [PSEL_W-1:0]        s1_psel_reg;
    logic signed [RATE_W-1:0] s1_rate_reg;
    logic [BSEL_W-1:0]        s1_bsel_reg;
    logic                     s1_level_reg;

    always_ff @(posedge clk)
    begin
        if (cmd_take)
        begin
            s1_op_reg     <= cmd.op;
            s1_cycles_reg <= cmd.cycles;
            s1_psel_reg   <= cmd.paddle_sel;
            s1_rate_reg   <= cmd.rate;
            s1_bsel_reg   <= cmd.button_sel;
            s1_level_reg  <= cmd.level;
        end
    end

    // ------------------------------------------------------------------
    // Paddle and button state
    // ------------------------------------------------------------------
    logic [POS_WIDTH-1:0]     position_reg  [NUM_PADDLES];
    logic [POS_WIDTH-1:0]     position_next [NUM_PADDLES];
    logic [POS_WIDTH-1:0]     countdown_reg [NUM_PADDLES];
    logic [POS_WIDTH-1:0]     countdown_next[NUM_PADDLES];
    logic signed [RATE_W-1:0] drift_reg     [NUM_PADDLES];
    logic signed [RATE_W-1:0] drift_next    [NUM_PADDLES];
    logic [NUM_BUTTONS-1:0]   pressed_reg;
    logic [NUM_BUTTONS-1:0]   pressed_next;

    // Per-paddle update: saturating tick, trigger load, clamped poll, set rate
    always_comb
    begin
        logic [XW-1:0]        cd_ext;
        logic [XW-1:0]        cy_ext;
        logic signed [SW-1:0] sum;
        logic signed [SW-1:0] lo_s;
        logic signed [SW-1:0] hi_s;

        cy_ext = XW'(s1_cycles_reg);
        lo_s   = $signed(SW'(lo_cap));
        hi_s   = $signed(SW'(hi_cap));
        for (int i = 0; i < NUM_PADDLES; i++)
        begin
            position_next[i]  = position_reg[i];
            countdown_next[i] = countdown_reg[i];
            drift_next[i]     = drift_reg[i];
            cd_ext = XW'(countdown_reg[i]);
            sum    = $signed(SW'(position_reg[i]))
                   + $signed({{(SW-RATE_W){drift_reg[i][RATE_W-1]}}, drift_reg[i]});
            if (sum > hi_s)
            begin
                sum = hi_s;
            end
            if (sum < lo_s)
            begin
                sum = lo_s;
            end
            if (fire)
            begin
                case (s1_op_reg)
                    OP_TICK:
                    begin
                        countdown_next[i] = (cd_ext > cy_ext)
                                          ? POS_WIDTH'(cd_ext - cy_ext) : '0;
                    end
                    OP_TRIGGER:
                    begin
                        countdown_next[i] = position_reg[i];
                    end
                    OP_POLL:
                    begin
                        position_next[i] = sum[POS_WIDTH-1:0];
                    end
                    OP_SET_RATE:
                    begin
                        if (32'(s1_psel_reg) == i)
                        begin
                            drift_next[i] = s1_rate_reg;
                        end
                    end
                    default:
                    begin
                        drift_next[i] = drift_reg[i];
                    end
                endcase
            end
        end
    end

    // Button flags; selector 3 is ignored
    always_comb
    begin
        pressed_next = pressed_reg;
        if (fire && (s1_op_reg == OP_BUTTON) && (32'(s1_bsel_reg) < NUM_BUTTONS))
        begin
            pressed_next[s1_bsel_reg] = s1_level_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_PADDLES; i++)
            begin
                position_reg[i]  <= '0;
                countdown_reg[i] <= '0;
                drift_reg[i]     <= '0;
            end
            pressed_reg <= '0;
        end
        else
        begin
            position_reg  <= position_next;
            countdown_reg <= countdown_next;
            drift_reg     <= drift_next;
            pressed_reg   <= pressed_next;
        end
    end

    // ------------------------------------------------------------------
    // Status register
    // ------------------------------------------------------------------
    logic [BUSY_W-1:0]      busy_next;
    logic [BUSY_W-1:0]      out_busy_reg;
    logic [NUM_BUTTONS-1:0] out_buttons_reg;

    always_comb
    begin
        busy_next = '0;
        for (int i = 0; i < BUSY_N; i++)
        begin
            busy_next[i] = (countdown_next[i] != '0);
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_busy_reg    <= busy_next;
            out_buttons_reg <= pressed_next;
        end
    end

    assign status.valid       = out_valid_reg;
    assign status.paddle_busy = out_busy_reg;
    assign status.buttons     = out_buttons_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // A status word only appears after a command sat in the input register
    a_out_from_s1: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s1_valid_reg))
        else $error("status word without a registered command");

    // Countdown of paddle 0 only grows on a trigger
    a_cd_monotone: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && (s1_op_reg != OP_TRIGGER))
        |=> (countdown_reg[0] <= $past(countdown_reg[0])))
        else $error("countdown grew without a trigger");

    // Busy bit reflects the updated countdown
    a_busy_match: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> (out_busy_reg[0] == (countdown_reg[0] != '0)))
        else $error("busy bit disagrees with countdown");

    // Buttons change only on a button command
    a_btn_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !(fire && (s1_op_reg == OP_BUTTON)) |=> $stable(pressed_reg))
        else $error("button flags changed without a button command");

endmodule : game_port_paddle_timers_top

`default_nettype wire
